// ===== src/dq_pkg.sv =====
// Package for the double-ended queue: command and status codes, beat types, cell control.
`timescale 1ns / 1ps
package dq_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int WORD_BITS_DEF = 32;

	typedef enum logic [1:0] {
		CMD_PUSH_BACK  = 2'd0,
		CMD_PUSH_FRONT = 2'd1,
		CMD_POP_BACK   = 2'd2,
		CMD_POP_FRONT  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t               cmd;
		logic signed [31:0] push_value;
	} in_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] pop_value;
		logic [4:0]         entry_count;
		logic               is_empty;
	} out_t;

	// One-hot or idle (all zero) operation applied to every cell in the same cycle.
	typedef struct packed {
		logic push_back;
		logic push_front;
		logic pop_back;
		logic pop_front;
	} cell_ctrl_t;

endpackage

// ===== src/dq_cell.sv =====
// One storage cell of the deque chain; position zero of the chain is the front.
`timescale 1ns / 1ps
module dq_cell #(
	parameter int WORD_BITS = dq_pkg::WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dq_pkg::cell_ctrl_t   ctrl,
	input  logic [WORD_BITS-1:0] push_word,
	input  logic                 left_valid,
	input  logic [WORD_BITS-1:0] left_word,
	input  logic                 right_valid,
	input  logic [WORD_BITS-1:0] right_word,
	output logic                 valid,
	output logic [WORD_BITS-1:0] word,
	output logic [WORD_BITS-1:0] tail_tap
);

	logic                 valid_q;
	logic [WORD_BITS-1:0] word_q;
	logic                 is_tail;
	logic                 is_slot;

	// The tail is the last held entry; the slot is the first free cell after it.
	assign is_tail = valid_q && !right_valid;
	assign is_slot = !valid_q && left_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.push_front) begin
			valid_q <= left_valid;
		end else if (ctrl.pop_front) begin
			valid_q <= right_valid;
		end else if (ctrl.push_back && is_slot) begin
			valid_q <= 1'b1;
		end else if (ctrl.pop_back && is_tail) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push_front) begin
			word_q <= left_word;
		end else if (ctrl.pop_front) begin
			word_q <= right_word;
		end else if (ctrl.push_back && is_slot) begin
			word_q <= push_word;
		end
	end

	assign valid    = valid_q;
	assign word     = word_q;
	assign tail_tap = is_tail ? word_q : '0;

endmodule

// ===== src/double_ended_queue.sv =====
// Top level of the double-ended queue: a chain of cells shifted toward the front or back.
// Latency: a result strobes on done in the cycle after its command is taken.
// Throughput: one command per cycle; busy stays low, since each cell updates from its
// neighbors on the same clock edge and the back entry is picked by one OR over the cell taps.
// Reset: arst_n empties the queue at once; stored words keep no reset value.
// The receiver cannot stall: each result stays on the result port until the next taken command replaces it.
`timescale 1ns / 1ps
module double_ended_queue #(
	parameter int DEPTH     = dq_pkg::DEPTH_DEF,
	parameter int WORD_BITS = dq_pkg::WORD_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  dq_pkg::in_t  item,
	output logic         done,
	output dq_pkg::out_t result
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     count_next;
	logic                 full;
	logic                 empty;
	logic                 accept;
	dq_pkg::cell_ctrl_t   ctrl;
	dq_pkg::status_t      status;
	logic [WORD_BITS-1:0] push_word;
	logic [WORD_BITS-1:0] front_word;
	logic [WORD_BITS-1:0] back_word;
	logic signed [WORD_BITS-1:0] pop_word;
	logic signed [31:0]   pop_value;

	logic                 valid_c [DEPTH];
	logic [WORD_BITS-1:0] word_c  [DEPTH];
	logic [WORD_BITS-1:0] tap_c   [DEPTH];

	logic         done_q;
	dq_pkg::out_t result_q;

	assign busy      = 1'b0;
	assign accept    = start && !busy;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign push_word = WORD_BITS'($unsigned(item.push_value));

	always_comb begin
		ctrl       = '0;
		status     = dq_pkg::ST_OK;
		count_next = count_q;
		if (accept) begin
			unique case (item.cmd)
				dq_pkg::CMD_PUSH_BACK, dq_pkg::CMD_PUSH_FRONT: begin
					if (full) begin
						status = dq_pkg::ST_FULL;
					end else begin
						ctrl.push_back  = (item.cmd == dq_pkg::CMD_PUSH_BACK);
						ctrl.push_front = (item.cmd == dq_pkg::CMD_PUSH_FRONT);
						count_next      = count_q + CNT_W'(1);
					end
				end
				dq_pkg::CMD_POP_BACK, dq_pkg::CMD_POP_FRONT: begin
					if (empty) begin
						status = dq_pkg::ST_EMPTY;
					end else begin
						ctrl.pop_back  = (item.cmd == dq_pkg::CMD_POP_BACK);
						ctrl.pop_front = (item.cmd == dq_pkg::CMD_POP_FRONT);
						count_next     = count_q - CNT_W'(1);
					end
				end
				default: begin
					status = dq_pkg::ST_OK;
				end
			endcase
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                 lv;
		logic [WORD_BITS-1:0] lw;
		logic                 rv;
		logic [WORD_BITS-1:0] rw;

		if (i == 0) begin : g_first
			assign lv = 1'b1;
			assign lw = push_word;
		end else begin : g_mid_left
			assign lv = valid_c[i-1];
			assign lw = word_c[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign rv = 1'b0;
			assign rw = '0;
		end else begin : g_mid_right
			assign rv = valid_c[i+1];
			assign rw = word_c[i+1];
		end

		dq_cell #(
			.WORD_BITS(WORD_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.push_word  (push_word),
			.left_valid (lv),
			.left_word  (lw),
			.right_valid(rv),
			.right_word (rw),
			.valid      (valid_c[i]),
			.word       (word_c[i]),
			.tail_tap   (tap_c[i])
		);
	end

	// Only the tail cell drives a nonzero tap, so an OR picks the back entry.
	always_comb begin
		back_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			back_word = back_word | tap_c[i];
		end
	end

	assign front_word = word_c[0];

	always_comb begin
		pop_word = '0;
		if (ctrl.pop_back) begin
			pop_word = back_word;
		end else if (ctrl.pop_front) begin
			pop_word = front_word;
		end
	end

	// Narrow words are sign-extended; wide words keep their low 32 bits.
	assign pop_value = 32'(pop_word);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_next;
			done_q  <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q.status      <= status;
			result_q.pop_value   <= pop_value;
			result_q.entry_count <= 5'(count_next);
			result_q.is_empty    <= (count_next == '0);
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
